@@ sv/bcmp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcmp_pkg
// Shared types and constants of the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package bcmp_pkg;

   // register map of the calibration port
   typedef enum logic [7:0] {
      REG_TEMP_CAL   = 8'd0,
      REG_PRESS_LOW  = 8'd1,
      REG_PRESS_HIGH = 8'd2,
      REG_PRESS_NINE = 8'd3
   } csr_index_type;

   // temperature calibration word, t1 in the low bits
   typedef struct packed {
      logic signed [15:0] t3;
      logic signed [15:0] t2;
      logic        [15:0] t1;
   } temp_cal_type;

   // pressure calibration words, p1 in the low bits
   typedef struct packed {
      logic signed [15:0] p9;
      logic signed [15:0] p8;
      logic signed [15:0] p7;
      logic signed [15:0] p6;
      logic signed [15:0] p5;
      logic signed [15:0] p4;
      logic signed [15:0] p3;
      logic signed [15:0] p2;
      logic        [15:0] p1;
   } press_cal_type;

   // data carried alongside the pressure path
   typedef struct packed {
      logic [31:0] centi;
      logic        zero;
   } side_type;

   localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
   localparam logic        [31:0] CENTI_ROUND = 32'd128;
   localparam logic        [20:0] PRESS_BASE  = 21'd1048576;
   localparam logic        [11:0] PRESS_SCALE = 12'd3125;
   localparam int unsigned        QUO_BITS    = 64;
   localparam int unsigned        DEN_BITS    = 31;

endpackage
`default_nettype wire

@@ sv/bcmp_temp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcmp_temp
// Four-stage temperature path: fine temperature, centi-degrees and the
// offset fine value that seeds the pressure path.
// ----------------------------------------------------------------------------
module bcmp_temp
   import bcmp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire logic [19:0]        raw_t,
   input  wire logic [19:0]        raw_p,
   input  wire temp_cal_type       tcal,
   output logic                    out_valid,
   output logic [31:0]             centi,
   output logic signed [32:0]      v1,
   output logic [19:0]             raw_p_out
);

   logic [3:0]         valid_ff;
   logic [19:0]        rp_a_ff, rp_b_ff, rp_c_ff, rp_d_ff;
   logic [31:0]        m1_ff, dd_ff, e1_ff, m2_ff, fine_ff, centi_ff;
   logic signed [32:0] v1_ff;

   // stage a: first-order and square products
   logic signed [18:0] a_diff;
   logic signed [16:0] a_d;
   logic signed [34:0] a_m1;
   logic signed [33:0] a_dd;
   assign a_diff = $signed({2'b00, raw_t[19:3]}) - $signed({2'b00, tcal.t1, 1'b0});
   assign a_d    = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, tcal.t1});
   assign a_m1   = a_diff * $signed(tcal.t2);
   assign a_dd   = a_d * a_d;

   // stage b: scale and second-order product
   logic signed [31:0] b_e1, b_x;
   logic signed [47:0] b_m2;
   assign b_e1 = $signed(m1_ff) >>> 11;
   assign b_x  = $signed(dd_ff) >>> 12;
   assign b_m2 = b_x * $signed(tcal.t3);

   // stage c: fine temperature
   logic signed [31:0] c_e2;
   logic [31:0]        c_fine;
   assign c_e2   = $signed(m2_ff) >>> 14;
   assign c_fine = e1_ff + c_e2;

   // stage d: centi-degrees and pressure seed
   logic [31:0]        d_sum;
   logic signed [31:0] d_centi;
   logic signed [32:0] d_v1;
   assign d_sum   = fine_ff + {fine_ff[29:0], 2'b00} + CENTI_ROUND;
   assign d_centi = $signed(d_sum) >>> 8;
   assign d_v1    = $signed({fine_ff[31], fine_ff}) - FINE_OFFSET;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_ff    <= a_m1[31:0];
         dd_ff    <= a_dd[31:0];
         rp_a_ff  <= raw_p;
         e1_ff    <= b_e1;
         m2_ff    <= b_m2[31:0];
         rp_b_ff  <= rp_a_ff;
         fine_ff  <= c_fine;
         rp_c_ff  <= rp_b_ff;
         centi_ff <= d_centi;
         v1_ff    <= d_v1;
         rp_d_ff  <= rp_c_ff;
      end
   end

   assign out_valid = valid_ff[3];
   assign centi     = centi_ff;
   assign v1        = v1_ff;
   assign raw_p_out = rp_d_ff;

endmodule
`default_nettype wire

@@ sv/bcmp_press.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcmp_press
// Five-stage front of the pressure path: forms the divisor and the scaled
// dividend of the pressure division.
// ----------------------------------------------------------------------------
module bcmp_press
   import bcmp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      in_valid,
   input  wire logic signed [32:0]        v1,
   input  wire logic [31:0]               centi,
   input  wire logic [19:0]               raw_p,
   input  wire press_cal_type             pcal,
   output logic                           out_valid,
   output logic [63:0]                    num,
   output logic [DEN_BITS-1:0]            den,
   output side_type                       side
);

   logic [4:0]         valid_ff;
   logic [19:0]        rp_e_ff, rp_f_ff, rp_g_ff;
   logic [31:0]        ce_ff, cf_ff, cg_ff, ch_ff;
   side_type           side_ff;
   logic [63:0]        sq_ff, a_ff, b_ff, v2_ff, s_ff, prod_ff, diff_ff, num_ff;
   logic signed [48:0] v1p5_ff, v1p2_ff, v1p5f_ff, v1p2f_ff;
   logic [DEN_BITS-1:0] den_ff;

   // stage e: square and linear products of the offset fine value
   logic signed [65:0] e_sq;
   logic signed [48:0] e_p5, e_p2;
   assign e_sq = v1 * v1;
   assign e_p5 = v1 * $signed(pcal.p5);
   assign e_p2 = v1 * $signed(pcal.p2);

   // stage f: square times calibration
   logic signed [79:0] f_a, f_b;
   assign f_a = $signed(sq_ff) * $signed(pcal.p6);
   assign f_b = $signed(sq_ff) * $signed(pcal.p3);

   // stage g: sum terms of both polynomials
   logic signed [63:0] g_p5x, g_p2x, g_p4x, g_bsh, g_v1b;
   logic [63:0]        g_v2, g_s;
   assign g_p5x = v1p5f_ff;
   assign g_p2x = v1p2f_ff;
   assign g_p4x = pcal.p4;
   assign g_bsh = $signed(b_ff) >>> 8;
   assign g_v2  = a_ff + (g_p5x <<< 17) + (g_p4x <<< 35);
   assign g_v1b = g_bsh + (g_p2x <<< 12);
   assign g_s   = 64'h0000_8000_0000_0000 + g_v1b;

   // stage h: divisor product and dividend offset
   logic [79:0] h_prod;
   logic [20:0] h_span;
   logic [63:0] h_diff;
   assign h_prod = s_ff * pcal.p1;
   assign h_span = PRESS_BASE - {1'b0, rp_g_ff};
   assign h_diff = {12'd0, h_span, 31'd0} - v2_ff;

   // stage i: scale dividend, take divisor
   logic [75:0] i_num;
   assign i_num = diff_ff * PRESS_SCALE;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff         <= e_sq[63:0];
         v1p5_ff       <= e_p5;
         v1p2_ff       <= e_p2;
         rp_e_ff       <= raw_p;
         ce_ff         <= centi;
         a_ff          <= f_a[63:0];
         b_ff          <= f_b[63:0];
         v1p5f_ff      <= v1p5_ff;
         v1p2f_ff      <= v1p2_ff;
         rp_f_ff       <= rp_e_ff;
         cf_ff         <= ce_ff;
         v2_ff         <= g_v2;
         s_ff          <= g_s;
         rp_g_ff       <= rp_f_ff;
         cg_ff         <= cf_ff;
         prod_ff       <= h_prod[63:0];
         diff_ff       <= h_diff;
         ch_ff         <= cg_ff;
         num_ff        <= i_num[63:0];
         den_ff        <= prod_ff[63:64-DEN_BITS];
         side_ff.centi <= ch_ff;
         side_ff.zero  <= (prod_ff[63:64-DEN_BITS] == '0);
      end
   end

   assign out_valid = valid_ff[4];
   assign num       = num_ff;
   assign den       = den_ff;
   assign side      = side_ff;

endmodule
`default_nettype wire

@@ sv/bcmp_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcmp_div
// Pipelined signed divider, truncating toward zero: a magnitude stage, one
// restoring stage per quotient bit and a sign stage.
// ----------------------------------------------------------------------------
module bcmp_div
   import bcmp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_valid,
   input  wire logic [63:0]          num,
   input  wire logic [DEN_BITS-1:0]  den,
   input  wire side_type             side_in,
   output logic                      out_valid,
   output logic [63:0]               quo,
   output side_type                  side_out
);

   logic [QUO_BITS:0]   valid_ff;
   logic [DEN_BITS-1:0] rem_ff  [QUO_BITS+1];
   logic [DEN_BITS-1:0] md_ff   [QUO_BITS+1];
   logic [63:0]         dvd_ff  [QUO_BITS+1];
   logic                neg_ff  [QUO_BITS+1];
   side_type            side_ff [QUO_BITS+1];
   logic                fin_valid_ff;
   logic [63:0]         quo_ff;
   side_type            fin_side_ff;

   // magnitude stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= '0;
         md_ff[0]   <= den[DEN_BITS-1] ? DEN_BITS'(-den) : den;
         dvd_ff[0]  <= num[63] ? -num : num;
         neg_ff[0]  <= num[63] ^ den[DEN_BITS-1];
         side_ff[0] <= side_in;
      end
   end

   // one quotient bit per stage
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_bit
      logic [DEN_BITS:0] trial;
      logic              fits;
      assign trial = {rem_ff[k], dvd_ff[k][63]};
      assign fits  = trial >= {1'b0, md_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= fits ? DEN_BITS'(trial - {1'b0, md_ff[k]})
                                 : trial[DEN_BITS-1:0];
            dvd_ff[k+1]  <= {dvd_ff[k][62:0], fits};
            md_ff[k+1]   <= md_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // sign stage
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (advance) begin
         fin_valid_ff <= valid_ff[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quo_ff      <= neg_ff[QUO_BITS] ? -dvd_ff[QUO_BITS] : dvd_ff[QUO_BITS];
         fin_side_ff <= side_ff[QUO_BITS];
      end
   end

   assign out_valid = fin_valid_ff;
   assign quo       = quo_ff;
   assign side_out  = fin_side_ff;

endmodule
`default_nettype wire

@@ sv/bcmp_post.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcmp_post
// Four-stage pressure correction after the division; its last stage is the
// output register of the block.
// ----------------------------------------------------------------------------
module bcmp_post
   import bcmp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          in_valid,
   input  wire logic [63:0]   quo,
   input  wire side_type      side_in,
   input  wire press_cal_type pcal,
   output logic               out_valid,
   output logic [31:0]        centi,
   output logic [31:0]        pressure,
   output logic               zero
);

   logic [3:0]  valid_ff;
   logic [63:0] p2_ff, p3_ff, p4_ff;
   side_type    s2_ff, s3_ff, s4_ff;
   logic [63:0] lo_ff, w2p_ff, hsq_ff, w2_ff, w1p_ff, w2b_ff;
   logic [31:0] cross_ff, press_ff, centi_ff;
   logic        zero_ff;

   // stage 2: partial products of h squared, p8 term
   logic signed [63:0] q2_h;
   logic [63:0]        q2_lo, q2_cross;
   logic signed [79:0] q2_w2p;
   assign q2_h     = $signed(quo) >>> 13;
   assign q2_lo    = q2_h[31:0] * q2_h[31:0];
   assign q2_cross = q2_h[63:32] * q2_h[31:0];
   assign q2_w2p   = $signed(quo) * $signed(pcal.p8);

   // stage 3: assemble low half of h squared
   logic [63:0]        q3_hsq;
   logic signed [63:0] q3_w2;
   assign q3_hsq = lo_ff + {cross_ff[30:0], 33'd0};
   assign q3_w2  = $signed(w2p_ff) >>> 19;

   // stage 4: p9 term
   logic signed [79:0] q4_w1p;
   assign q4_w1p = $signed(hsq_ff) * $signed(pcal.p9);

   // stage 5: final sum
   logic signed [63:0] q5_w1, q5_sum, q5_sh, q5_p7, q5_res;
   assign q5_w1  = $signed(w1p_ff) >>> 25;
   assign q5_sum = $signed(p4_ff) + q5_w1 + $signed(w2b_ff);
   assign q5_sh  = q5_sum >>> 8;
   assign q5_p7  = pcal.p7;
   assign q5_res = q5_sh + (q5_p7 <<< 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_ff    <= quo;
         s2_ff    <= side_in;
         lo_ff    <= q2_lo;
         cross_ff <= q2_cross[31:0];
         w2p_ff   <= q2_w2p[63:0];
         p3_ff    <= p2_ff;
         s3_ff    <= s2_ff;
         hsq_ff   <= q3_hsq;
         w2_ff    <= q3_w2;
         p4_ff    <= p3_ff;
         s4_ff    <= s3_ff;
         w1p_ff   <= q4_w1p[63:0];
         w2b_ff   <= w2_ff;
         press_ff <= s4_ff.zero ? '0 : q5_res[31:0];
         centi_ff <= s4_ff.centi;
         zero_ff  <= s4_ff.zero;
      end
   end

   assign out_valid = valid_ff[3];
   assign centi     = centi_ff;
   assign pressure  = press_ff;
   assign zero      = zero_ff;

endmodule
`default_nettype wire

@@ sv/barometer_compensation_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// barometer_compensation_core
// Integer compensation of raw barometer temperature and pressure readings.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless stalled and returns one result per
// request, in order, through 4 stages of temperature, 5 stages forming the
// pressure dividend and divisor, 66 stages of divider (one quotient bit per
// stage plus magnitude and sign stages) and 4 correction stages, the last of
// which is the output register. The whole pipeline holds while a result waits
// on rsp_ready. Calibration registers are written through the csr port, which
// is always ready; indexes above three are ignored. Calibration is read live
// by the stages that use it and must only change while the pipeline is empty.
// A zero divisor gives pressure 0 with rsp_divisor_zero set.
module barometer_compensation_core
   import bcmp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [19:0]  req_raw_temperature,
   input  wire logic [19:0]  req_raw_pressure,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic signed [31:0] rsp_temperature_centi,
   output logic [31:0]       rsp_pressure_q24_8,
   output logic              rsp_divisor_zero,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [63:0]  csr_data
);

   temp_cal_type        temp_cal_ff;
   logic [63:0]         press_low_ff, press_high_ff;
   logic [15:0]         press_nine_ff;
   press_cal_type       pcal;
   logic                advance;

   logic                t_valid;
   logic [31:0]         t_centi;
   logic signed [32:0]  t_v1;
   logic [19:0]         t_raw_p;
   logic                p_valid;
   logic [63:0]         p_num;
   logic [DEN_BITS-1:0] p_den;
   side_type            p_side;
   logic                d_valid;
   logic [63:0]         d_quo;
   side_type            d_side;
   logic [31:0]         o_centi;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff   <= '0;
         press_low_ff  <= '0;
         press_high_ff <= '0;
         press_nine_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TEMP_CAL:   temp_cal_ff   <= temp_cal_type'(csr_data[47:0]);
            REG_PRESS_LOW:  press_low_ff  <= csr_data;
            REG_PRESS_HIGH: press_high_ff <= csr_data;
            REG_PRESS_NINE: press_nine_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign pcal      = {press_nine_ff, press_high_ff, press_low_ff};

   // global pipeline advance
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   bcmp_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .raw_t     (req_raw_temperature),
      .raw_p     (req_raw_pressure),
      .tcal      (temp_cal_ff),
      .out_valid (t_valid),
      .centi     (t_centi),
      .v1        (t_v1),
      .raw_p_out (t_raw_p)
   );

   bcmp_press u_press (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (t_valid),
      .v1        (t_v1),
      .centi     (t_centi),
      .raw_p     (t_raw_p),
      .pcal      (pcal),
      .out_valid (p_valid),
      .num       (p_num),
      .den       (p_den),
      .side      (p_side)
   );

   bcmp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p_valid),
      .num       (p_num),
      .den       (p_den),
      .side_in   (p_side),
      .out_valid (d_valid),
      .quo       (d_quo),
      .side_out  (d_side)
   );

   bcmp_post u_post (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d_valid),
      .quo       (d_quo),
      .side_in   (d_side),
      .pcal      (pcal),
      .out_valid (rsp_valid),
      .centi     (o_centi),
      .pressure  (rsp_pressure_q24_8),
      .zero      (rsp_divisor_zero)
   );

   assign rsp_temperature_centi = o_centi;

`ifndef SYNTHESIS
   // a zero divisor always reports zero pressure
   a_zero_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divisor_zero |-> rsp_pressure_q24_8 == '0)
      else $error("pressure not cleared on zero divisor");

   // a stalled result blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
